// File: sv/assert_macros.svh
// Assertion macros for the controller RTL.
// Define ASSERT_OFF to compile every check away; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: sv/gphc_pkg.sv
// Types, constants and the arctangent table of the pose heading controller.
// No dependencies; the prep, cell, finish and top modules refer to it by scoped names.
`timescale 1ns / 1ps

package gphc_pkg;

   localparam int XW        = 34;   // CORDIC x/y datapath width
   localparam int ZW        = 33;   // angle accumulator width (16 fraction bits)
   localparam int ATAN_LEN  = 24;
   localparam int XY_SHIFT  = 14;
   localparam int ANG_FRAC  = 16;

   localparam logic signed [ZW-1:0] QUARTER_Z = 33'sd589824000;   // 9000 << 16
   localparam logic signed [ZW-1:0] ROUND_Z   = 33'sd32768;

   localparam logic signed [17:0] WRAP_HI2  = 18'sd54000;
   localparam logic signed [17:0] WRAP_HI1  = 18'sd18000;
   localparam logic signed [17:0] WRAP_LO1  = -18'sd18000;
   localparam logic signed [17:0] WRAP_LO2  = -18'sd54000;
   localparam logic signed [17:0] FULL_TURN = 18'sd36000;
   localparam logic signed [17:0] TWO_TURNS = 18'sd72000;

   typedef enum logic [1:0] {
      REG_WALK_STEP    = 2'd0,
      REG_STOP_DIST    = 2'd1,
      REG_HEADING_TOL  = 2'd2,
      REG_TURN_LIMIT   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [9:0]  walk_step;
      logic [29:0] stop_sq;
      logic [15:0] heading_tol;
      logic [14:0] turn_limit;
   } cfg_type;

   // Sideband that rides along the CORDIC chain with each pose
   typedef struct packed {
      logic               walk;
      logic               tol_miss;
      logic signed [15:0] self_heading;
      logic signed [15:0] target_heading;
   } side_type;

   // atan(2^-i) in 0.01 deg with 16 fraction bits
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:       val = 33'sd294912000;
         1:       val = 33'sd174096719;
         2:       val = 33'sd91987925;
         3:       val = 33'sd46694507;
         4:       val = 33'sd23437865;
         5:       val = 33'sd11730358;
         6:       val = 33'sd5866610;
         7:       val = 33'sd2933484;
         8:       val = 33'sd1466765;
         9:       val = 33'sd733385;
         10:      val = 33'sd366693;
         11:      val = 33'sd183346;
         12:      val = 33'sd91673;
         13:      val = 33'sd45837;
         14:      val = 33'sd22918;
         15:      val = 33'sd11459;
         16:      val = 33'sd5730;
         17:      val = 33'sd2865;
         18:      val = 33'sd1432;
         19:      val = 33'sd716;
         20:      val = 33'sd358;
         21:      val = 33'sd179;
         22:      val = 33'sd90;
         23:      val = 33'sd45;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: sv/gphc_req_if.sv
// Request channel: current pose and target pose, valid/ready handshake.
// No dependencies.
`timescale 1ns / 1ps

interface gphc_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] self_x;
   logic signed [15:0] self_y;
   logic signed [15:0] self_heading;
   logic signed [15:0] target_x;
   logic signed [15:0] target_y;
   logic signed [15:0] target_heading;

   modport source (output valid, self_x, self_y, self_heading,
                   target_x, target_y, target_heading, input ready);
   modport sink   (input valid, self_x, self_y, self_heading,
                   target_x, target_y, target_heading, output ready);
endinterface

// File: sv/gphc_rsp_if.sv
// Response channel: walk/ready action, step and turn commands.
// No dependencies.
`timescale 1ns / 1ps

interface gphc_rsp_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic [9:0]         step_cmd;
   logic signed [15:0] turn_cmd;

   modport source (output valid, action, step_cmd, turn_cmd, input ready);
   modport sink   (input valid, action, step_cmd, turn_cmd, output ready);
endinterface

// File: sv/gphc_prep.sv
// Front end: pose differences, distance test, tolerance test and quadrant
// pre-rotation ahead of the CORDIC chain. Depends on gphc_pkg.
`timescale 1ns / 1ps

module gphc_prep (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  gphc_pkg::cfg_type              cfg,
   input  logic                           valid_i,
   input  logic signed [15:0]             self_x,
   input  logic signed [15:0]             self_y,
   input  logic signed [15:0]             self_heading,
   input  logic signed [15:0]             target_x,
   input  logic signed [15:0]             target_y,
   input  logic signed [15:0]             target_heading,
   output logic                           valid_o,
   output logic signed [17:0]             x_o,
   output logic signed [17:0]             y_o,
   output logic signed [gphc_pkg::ZW-1:0] z_o,
   output gphc_pkg::side_type             side_o
);

   // stage 1: differences
   logic                    v1_ff;
   logic signed [16:0]      dx_ff, dy_ff, diff_ff;
   logic signed [15:0]      sh1_ff, th1_ff;
   // stage 2: squares, tolerance, pre-rotation
   logic                    v2_ff, v2_in;
   logic [31:0]             sqx_ff, sqy_ff;
   logic                    tol2_ff, tol2_in;
   logic signed [17:0]      x2_ff, y2_ff, x2_in, y2_in;
   logic signed [gphc_pkg::ZW-1:0] z2_ff, z2_in;
   logic signed [15:0]      sh2_ff, th2_ff;
   // stage 3: distance compare
   logic                    v3_ff;
   logic signed [17:0]      x3_ff, y3_ff;
   logic signed [gphc_pkg::ZW-1:0] z3_ff;
   gphc_pkg::side_type      side3_ff, side3_in;

   logic signed [17:0]      dx_e, dy_e;
   logic signed [33:0]      sqx_full, sqy_full;
   logic [16:0]             diff_abs;
   logic [32:0]             dist2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= valid_i;
         v2_ff <= v2_in;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         dx_ff   <= 17'(target_x) - 17'(self_x);
         dy_ff   <= 17'(target_y) - 17'(self_y);
         diff_ff <= 17'(self_heading) - 17'(target_heading);
         sh1_ff  <= self_heading;
         th1_ff  <= target_heading;

         sqx_ff  <= sqx_full[31:0];
         sqy_ff  <= sqy_full[31:0];
         tol2_ff <= tol2_in;
         x2_ff   <= x2_in;
         y2_ff   <= y2_in;
         z2_ff   <= z2_in;
         sh2_ff  <= sh1_ff;
         th2_ff  <= th1_ff;

         x3_ff    <= x2_ff;
         y3_ff    <= y2_ff;
         z3_ff    <= z2_ff;
         side3_ff <= side3_in;
      end
   end

   always_comb begin
      v2_in    = v1_ff;
      dx_e     = 18'(dx_ff);
      dy_e     = 18'(dy_ff);
      sqx_full = 34'(dx_ff) * 34'(dx_ff);
      sqy_full = 34'(dy_ff) * 34'(dy_ff);
      diff_abs = diff_ff[16] ? 17'(-diff_ff) : 17'(diff_ff);
      tol2_in  = diff_abs > {1'b0, cfg.heading_tol};

      // rotate into the right half plane
      if (dx_ff[16]) begin
         if (!dy_ff[16]) begin
            x2_in = dy_e;
            y2_in = -dx_e;
            z2_in = gphc_pkg::QUARTER_Z;
         end else begin
            x2_in = -dy_e;
            y2_in = dx_e;
            z2_in = -gphc_pkg::QUARTER_Z;
         end
      end else begin
         x2_in = dx_e;
         y2_in = dy_e;
         z2_in = '0;
      end

      dist2                   = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      side3_in.walk           = dist2 > {3'b000, cfg.stop_sq};
      side3_in.tol_miss       = tol2_ff;
      side3_in.self_heading   = sh2_ff;
      side3_in.target_heading = th2_ff;
   end

   assign valid_o = v3_ff;
   assign x_o     = x3_ff;
   assign y_o     = y3_ff;
   assign z_o     = z3_ff;
   assign side_o  = side3_ff;

endmodule

// File: sv/gphc_cell.sv
// One CORDIC vectoring cell: a fixed shift and arctangent, one rotation
// per cycle on advance, registered for the next cell. Depends on gphc_pkg.
`timescale 1ns / 1ps

module gphc_cell #(
   parameter int SHIFT = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           valid_i,
   input  logic signed [gphc_pkg::XW-1:0] x_i,
   input  logic signed [gphc_pkg::XW-1:0] y_i,
   input  logic signed [gphc_pkg::ZW-1:0] z_i,
   input  gphc_pkg::side_type             side_i,
   output logic                           valid_o,
   output logic signed [gphc_pkg::XW-1:0] x_o,
   output logic signed [gphc_pkg::XW-1:0] y_o,
   output logic signed [gphc_pkg::ZW-1:0] z_o,
   output gphc_pkg::side_type             side_o
);

   localparam logic signed [gphc_pkg::ZW-1:0] ANGLE = gphc_pkg::atan_entry(SHIFT);

   logic                           valid_ff;
   logic signed [gphc_pkg::XW-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [gphc_pkg::ZW-1:0] z_ff, z_in;
   gphc_pkg::side_type             side_ff;

   always_comb begin
      xs = x_i >>> SHIFT;
      ys = y_i >>> SHIFT;
      // y at or above zero: rotate clockwise
      if (!y_i[gphc_pkg::XW-1]) begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ANGLE;
      end else begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= side_i;
      end
   end

   assign valid_o = valid_ff;
   assign x_o     = x_ff;
   assign y_o     = y_ff;
   assign z_o     = z_ff;
   assign side_o  = side_ff;

endmodule

// File: sv/gphc_finish.sv
// Back end: azimuth rounding, heading error, wrap, clamp and the response
// register. Depends on gphc_pkg.
`timescale 1ns / 1ps

module gphc_finish (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  gphc_pkg::cfg_type              cfg,
   input  logic                           valid_i,
   input  logic signed [gphc_pkg::ZW-1:0] z_i,
   input  gphc_pkg::side_type             side_i,
   output logic                           valid_o,
   output logic                           action_o,
   output logic [9:0]                     step_o,
   output logic signed [15:0]             turn_o
);

   logic                           v1_ff, v2_ff, out_valid_ff;
   logic                           walk1_ff, tol1_ff, walk2_ff, tol2_ff;
   logic signed [17:0]             d_ff, d_in;
   logic signed [15:0]             w_ff, w_in;
   logic                           action_ff, action_in;
   logic [9:0]                     step_ff, step_in;
   logic signed [15:0]             turn_ff, turn_in;

   logic signed [gphc_pkg::ZW-1:0] z_round;
   logic signed [16:0]             az;
   logic signed [17:0]             sh_e, th_e, wrapped;
   logic signed [16:0]             lim_s, w_e;

   always_comb begin
      z_round = z_i + gphc_pkg::ROUND_Z;
      az      = z_round[gphc_pkg::ZW-1:gphc_pkg::ANG_FRAC];
      sh_e    = 18'(side_i.self_heading);
      th_e    = 18'(side_i.target_heading);
      d_in    = side_i.walk ? (18'(az) - sh_e) : (th_e - sh_e);

      // bring the error into (-18000, 18000]
      if (d_ff > gphc_pkg::WRAP_HI2) begin
         wrapped = d_ff - gphc_pkg::TWO_TURNS;
      end else if (d_ff > gphc_pkg::WRAP_HI1) begin
         wrapped = d_ff - gphc_pkg::FULL_TURN;
      end else if (d_ff > gphc_pkg::WRAP_LO1) begin
         wrapped = d_ff;
      end else if (d_ff > gphc_pkg::WRAP_LO2) begin
         wrapped = d_ff + gphc_pkg::FULL_TURN;
      end else begin
         wrapped = d_ff + gphc_pkg::TWO_TURNS;
      end
      w_in = wrapped[15:0];

      lim_s     = signed'({2'b00, cfg.turn_limit});
      w_e       = 17'(w_ff);
      action_in = !walk2_ff && !tol2_ff;
      step_in   = walk2_ff ? cfg.walk_step : '0;
      if (action_in) begin
         turn_in = '0;
      end else if (w_e > lim_s) begin
         turn_in = lim_s[15:0];
      end else if (w_e < -lim_s) begin
         turn_in = 16'(-lim_s);
      end else begin
         turn_in = w_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= valid_i;
         v2_ff        <= v1_ff;
         out_valid_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         d_ff      <= d_in;
         walk1_ff  <= side_i.walk;
         tol1_ff   <= side_i.tol_miss;
         w_ff      <= w_in;
         walk2_ff  <= walk1_ff;
         tol2_ff   <= tol1_ff;
         action_ff <= action_in;
         step_ff   <= step_in;
         turn_ff   <= turn_in;
      end
   end

   assign valid_o  = out_valid_ff;
   assign action_o = action_ff;
   assign step_o   = step_ff;
   assign turn_o   = turn_ff;

endmodule

// File: sv/goto_pose_heading_controller_top.sv
// Pose heading controller: accepts one pose per cycle; each response
// passes three front-end stages, the CORDIC cells and three back-end
// stages incl. output.
// Throughput is one transaction per cycle; a stalled response freezes the
// whole chain. Synchronous reset empties the chain and loads register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module goto_pose_heading_controller_top #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   gphc_req_if.sink    req_ch,
   gphc_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int N = (CORDIC_STAGES < gphc_pkg::ATAN_LEN) ?
                      CORDIC_STAGES : gphc_pkg::ATAN_LEN;

   logic [9:0]  walk_step_ff;
   logic [14:0] stop_dist_ff;
   logic [29:0] stop_sq_ff;
   logic [15:0] heading_tol_ff;
   logic [14:0] turn_limit_ff;
   gphc_pkg::cfg_type cfg;

   logic advance;
   logic out_valid;

   logic                           prep_valid;
   logic signed [17:0]             prep_x, prep_y;
   logic signed [gphc_pkg::ZW-1:0] prep_z;
   gphc_pkg::side_type             prep_side;

   logic                           v_chain [0:N];
   logic signed [gphc_pkg::XW-1:0] x_chain [0:N];
   logic signed [gphc_pkg::XW-1:0] y_chain [0:N];
   logic signed [gphc_pkg::ZW-1:0] z_chain [0:N];
   gphc_pkg::side_type             s_chain [0:N];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         walk_step_ff   <= 10'd350;
         stop_dist_ff   <= 15'd200;
         heading_tol_ff <= 16'd1000;
         turn_limit_ff  <= 15'd1000;
      end else if (csr_wr_en) begin
         case (csr_index)
            gphc_pkg::REG_WALK_STEP:   walk_step_ff   <= csr_data[9:0];
            gphc_pkg::REG_STOP_DIST:   stop_dist_ff   <= csr_data[14:0];
            gphc_pkg::REG_HEADING_TOL: heading_tol_ff <= csr_data;
            gphc_pkg::REG_TURN_LIMIT:  turn_limit_ff  <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      stop_sq_ff <= 30'(stop_dist_ff) * 30'(stop_dist_ff);
   end

   always_comb begin
      cfg.walk_step   = walk_step_ff;
      cfg.stop_sq     = stop_sq_ff;
      cfg.heading_tol = heading_tol_ff;
      cfg.turn_limit  = turn_limit_ff;
   end

   // advance the whole chain unless a finished response is held
   assign advance      = !out_valid || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign rsp_ch.valid = out_valid;

   gphc_prep u_prep (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .cfg            (cfg),
      .valid_i        (req_ch.valid),
      .self_x         (req_ch.self_x),
      .self_y         (req_ch.self_y),
      .self_heading   (req_ch.self_heading),
      .target_x       (req_ch.target_x),
      .target_y       (req_ch.target_y),
      .target_heading (req_ch.target_heading),
      .valid_o        (prep_valid),
      .x_o            (prep_x),
      .y_o            (prep_y),
      .z_o            (prep_z),
      .side_o         (prep_side)
   );

   assign v_chain[0] = prep_valid;
   assign x_chain[0] = {{(gphc_pkg::XW - 18 - gphc_pkg::XY_SHIFT){prep_x[17]}},
                        prep_x, {gphc_pkg::XY_SHIFT{1'b0}}};
   assign y_chain[0] = {{(gphc_pkg::XW - 18 - gphc_pkg::XY_SHIFT){prep_y[17]}},
                        prep_y, {gphc_pkg::XY_SHIFT{1'b0}}};
   assign z_chain[0] = prep_z;
   assign s_chain[0] = prep_side;

   for (genvar g = 0; g < N; g++) begin : g_cell
      gphc_cell #(
         .SHIFT (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .valid_i (v_chain[g]),
         .x_i     (x_chain[g]),
         .y_i     (y_chain[g]),
         .z_i     (z_chain[g]),
         .side_i  (s_chain[g]),
         .valid_o (v_chain[g+1]),
         .x_o     (x_chain[g+1]),
         .y_o     (y_chain[g+1]),
         .z_o     (z_chain[g+1]),
         .side_o  (s_chain[g+1])
      );
   end

   gphc_finish u_finish (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .cfg      (cfg),
      .valid_i  (v_chain[N]),
      .z_i      (z_chain[N]),
      .side_i   (s_chain[N]),
      .valid_o  (out_valid),
      .action_o (rsp_ch.action),
      .step_o   (rsp_ch.step_cmd),
      .turn_o   (rsp_ch.turn_cmd)
   );

   `ASSERT_IMPLY(a_ready_quiet, clock, reset, rsp_ch.valid && rsp_ch.action, rsp_ch.step_cmd == 10'd0 && rsp_ch.turn_cmd == 16'sd0)
   `ASSERT_IMPLY(a_turn_range, clock, reset, rsp_ch.valid, rsp_ch.turn_cmd <= 16'sd18000 && rsp_ch.turn_cmd >= -16'sd18000)
   `ASSERT_NEXT(a_chain_frozen, clock, reset, rsp_ch.valid && !rsp_ch.ready, $stable(v_chain[N]) && $stable(z_chain[N]))

endmodule
